[src/minimax_path_relaxation_macros.svh]
// Assertion macros shared by the block.
`ifndef MINIMAX_PATH_RELAXATION_MACROS_SVH
`define MINIMAX_PATH_RELAXATION_MACROS_SVH

// Same-cycle implication, sampled on clk and idle while in reset.
`define MPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while in reset.
`define MPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/mmpr_pkg.sv]
package mmpr_pkg;

	localparam int DEF_MAX_NODES   = 512;
	localparam int DEF_MAX_EDGES   = 16384;
	localparam int DEF_WEIGHT_BITS = 16;

	localparam logic [9:0] NODE_COUNT_RESET = 10'd512;

	// Input word operation codes.
	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_SOLVE = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	// Result word kinds.
	localparam logic KIND_SOLVE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Write request from the relax unit to the cost store.
	typedef struct packed {
		logic wr_en;
		logic to_b;
	} relax_ctl_t;

endpackage

[src/mmpr_edge_mem.sv]
module mmpr_edge_mem import mmpr_pkg::*; #(
	parameter int DEPTH = DEF_MAX_EDGES,
	parameter int DW    = 18 + DEF_WEIGHT_BITS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/mmpr_cost_mem.sv]
module mmpr_cost_mem import mmpr_pkg::*; #(
	parameter int NODES = DEF_MAX_NODES,
	parameter int CW    = DEF_WEIGHT_BITS + 1,
	parameter int AW    = $clog2(NODES)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [CW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [CW-1:0] rdata_a,
	output logic [CW-1:0] rdata_b
);

	logic [CW-1:0] mem [NODES];
	logic [CW-1:0] rdata_a_q;
	logic [CW-1:0] rdata_b_q;

	// One write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

[src/mmpr_relax_unit.sv]
module mmpr_relax_unit import mmpr_pkg::*; #(
	parameter int WB = DEF_WEIGHT_BITS
) (
	input  logic [WB:0]   cost_a,
	input  logic [WB:0]   cost_b,
	input  logic [WB-1:0] w,
	output relax_ctl_t    ctl,
	output logic [WB:0]   new_cost
);

	localparam logic [WB:0] INF = {1'b1, {WB{1'b0}}};

	logic [WB:0] w_ext;
	logic [WB:0] via_a;
	logic [WB:0] via_b;

	assign w_ext = {1'b0, w};
	assign via_a = (cost_a > w_ext) ? cost_a : w_ext;
	assign via_b = (cost_b > w_ext) ? cost_b : w_ext;

	// Relax the edge in both directions; at most one side can improve.
	always_comb begin
		ctl      = '0;
		new_cost = via_a;
		if (cost_a < INF && via_a < cost_b) begin
			ctl.wr_en = 1'b1;
			ctl.to_b  = 1'b1;
			new_cost  = via_a;
		end else if (cost_b < INF && via_b < cost_a) begin
			ctl.wr_en = 1'b1;
			ctl.to_b  = 1'b0;
			new_cost  = via_b;
		end
	end

endmodule

[src/minimax_path_relaxation.sv]
// Add-edge and clear words give no result; busy stays low.
// A read passes through S_READ and gives its result word from the registered cost read.
// A solve first resets the cost store and seeds the start node, then sweeps the stored
// edges, each through S_EDGE, S_NODE and S_RELAX, until a sweep changes nothing.
// A bad start gives its result word after the clearing pass, with no sweeps.
// After reset a clearing pass over all MAX_NODES entries holds busy high. The receiver cannot stall.
module minimax_path_relaxation import mmpr_pkg::*; #(
	parameter int MAX_NODES   = DEF_MAX_NODES,
	parameter int MAX_EDGES   = DEF_MAX_EDGES,
	parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [8:0]  node_a,
	input  logic [8:0]  node_b,
	input  logic [15:0] weight,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	output logic        done,
	output logic        kind,
	output logic [8:0]  node_id,
	output logic [15:0] path_cost,
	output logic        reachable,
	output logic        error_flag
);

	`include "minimax_path_relaxation_macros.svh"

	localparam int WB   = WEIGHT_BITS;
	localparam int CW   = WB + 1;
	localparam int NW   = $clog2(MAX_NODES);
	localparam int NCW  = $clog2(MAX_NODES + 1);
	localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ETW  = $clog2(MAX_EDGES + 1);
	localparam int EDW  = 18 + WB;
	localparam logic [CW-1:0]  INF      = {1'b1, {WB{1'b0}}};
	localparam logic [NW-1:0]  LAST_IDX = NW'(MAX_NODES - 1);
	localparam logic [ETW-1:0] FULL     = ETW'(MAX_EDGES);

	typedef enum logic [2:0] {
		S_IDLE, S_CLEAR, S_SEED, S_EDGE, S_NODE, S_RELAX, S_READ
	} state_t;

	state_t        state_q;
	logic [9:0]    cfg_q;
	logic [ETW-1:0] edge_total_q;
	logic [ETW-1:0] edge_idx_q;
	logic [NW-1:0] clr_idx_q;
	logic          err_q;
	logic          emit_q;
	logic          ok_q;
	logic          changed_q;
	logic [8:0]    node_q;
	logic          done_q;
	logic          kind_q;
	logic [8:0]    node_id_q;
	logic [15:0]   path_cost_q;
	logic          reachable_q;

	logic [NCW-1:0] n_eff;
	logic           accept;
	logic           a_ok;
	logic           b_ok;
	logic [31:0]    w32;
	logic [WB-1:0]  w_in;

	logic [EDW-1:0] edge_rd;
	logic [8:0]     e_a;
	logic [8:0]     e_b;
	logic [WB-1:0]  e_w;
	logic           e_ok;

	logic           c_we;
	logic [NW-1:0]  c_waddr;
	logic [CW-1:0]  c_wdata;
	logic [NW-1:0]  c_raddr_a;
	logic [NW-1:0]  c_raddr_b;
	logic [CW-1:0]  c_rdata_a;
	logic [CW-1:0]  c_rdata_b;

	relax_ctl_t     rlx_ctl;
	logic [CW-1:0]  rlx_cost;
	logic [31:0]    cost32;

	// Effective node count and input checks.
	always_comb begin
		if (32'(cfg_q) < MAX_NODES) begin
			n_eff = NCW'(cfg_q);
		end else begin
			n_eff = NCW'(MAX_NODES);
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign a_ok   = 32'(node_a) < 32'(n_eff);
	assign b_ok   = 32'(node_b) < 32'(n_eff);
	assign w32    = 32'(weight);
	assign w_in   = w32[WB-1:0];

	// Edge store, packed as weight, endpoint b, endpoint a.
	mmpr_edge_mem #(.DEPTH(MAX_EDGES), .DW(EDW), .AW(EAW)) u_edges (
		.clk   (clk),
		.we    (accept && action == ACT_ADD && a_ok && b_ok && edge_total_q != FULL),
		.waddr (edge_total_q[EAW-1:0]),
		.wdata ({w_in, node_b, node_a}),
		.raddr (edge_idx_q[EAW-1:0]),
		.rdata (edge_rd)
	);

	assign e_a  = edge_rd[8:0];
	assign e_b  = edge_rd[17:9];
	assign e_w  = edge_rd[EDW-1:18];
	assign e_ok = (32'(e_a) < 32'(n_eff)) && (32'(e_b) < 32'(n_eff));

	// Cost store read addresses: edge endpoints in S_NODE, else the input node.
	always_comb begin
		if (state_q == S_NODE) begin
			c_raddr_a = NW'(32'(e_a));
			c_raddr_b = NW'(32'(e_b));
		end else begin
			c_raddr_a = NW'(32'(node_a));
			c_raddr_b = NW'(32'(node_a));
		end
	end

	// Cost store write port: clearing pass, start seed or relaxation.
	// Stale edges leave the costs alone.
	always_comb begin
		c_we    = 1'b0;
		c_waddr = clr_idx_q;
		c_wdata = INF;
		case (state_q)
			S_CLEAR: begin
				c_we = 1'b1;
			end
			S_SEED: begin
				c_we    = 1'b1;
				c_waddr = NW'(32'(node_q));
				c_wdata = '0;
			end
			S_RELAX: begin
				c_we    = rlx_ctl.wr_en && e_ok;
				c_waddr = rlx_ctl.to_b ? NW'(32'(e_b)) : NW'(32'(e_a));
				c_wdata = rlx_cost;
			end
			default: begin
				c_we = 1'b0;
			end
		endcase
	end

	mmpr_cost_mem #(.NODES(MAX_NODES), .CW(CW), .AW(NW)) u_costs (
		.clk     (clk),
		.we      (c_we),
		.waddr   (c_waddr),
		.wdata   (c_wdata),
		.raddr_a (c_raddr_a),
		.raddr_b (c_raddr_b),
		.rdata_a (c_rdata_a),
		.rdata_b (c_rdata_b)
	);

	mmpr_relax_unit #(.WB(WB)) u_relax (
		.cost_a   (c_rdata_a),
		.cost_b   (c_rdata_b),
		.w        (e_w),
		.ctl      (rlx_ctl),
		.new_cost (rlx_cost)
	);

	assign cost32 = 32'(c_rdata_a);

	// Sequencer with registered result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cfg_q        <= NODE_COUNT_RESET;
			edge_total_q <= '0;
			edge_idx_q   <= '0;
			clr_idx_q    <= '0;
			err_q        <= 1'b0;
			emit_q       <= 1'b0;
			ok_q         <= 1'b0;
			changed_q    <= 1'b0;
			node_q       <= '0;
			done_q       <= 1'b0;
			kind_q       <= KIND_SOLVE;
			node_id_q    <= '0;
			path_cost_q  <= '0;
			reachable_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						node_q <= node_a;
						ok_q   <= a_ok;
						case (action)
							ACT_CLEAR: begin
								edge_total_q <= '0;
							end
							ACT_ADD: begin
								if (a_ok && b_ok && edge_total_q != FULL) begin
									edge_total_q <= edge_total_q + 1'b1;
								end else begin
									err_q <= 1'b1;
								end
							end
							ACT_SOLVE: begin
								if (!a_ok) begin
									err_q <= 1'b1;
								end
								clr_idx_q <= '0;
								emit_q    <= 1'b1;
								state_q   <= S_CLEAR;
							end
							default: begin
								if (!a_ok) begin
									err_q <= 1'b1;
								end
								state_q <= S_READ;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						if (emit_q && ok_q) begin
							state_q <= S_SEED;
						end else begin
							done_q      <= emit_q;
							kind_q      <= KIND_SOLVE;
							node_id_q   <= node_q;
							path_cost_q <= '0;
							reachable_q <= 1'b0;
							emit_q      <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
				end
				S_SEED: begin
					edge_idx_q <= '0;
					changed_q  <= 1'b0;
					if (edge_total_q == '0) begin
						done_q      <= 1'b1;
						kind_q      <= KIND_SOLVE;
						node_id_q   <= node_q;
						path_cost_q <= '0;
						reachable_q <= 1'b1;
						emit_q      <= 1'b0;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					state_q <= S_NODE;
				end
				S_NODE: begin
					state_q <= S_RELAX;
				end
				S_RELAX: begin
					// Stale edges leave the costs alone.
					if (e_ok && rlx_ctl.wr_en) begin
						changed_q <= 1'b1;
					end
					if (edge_idx_q + 1'b1 == edge_total_q) begin
						edge_idx_q <= '0;
						changed_q  <= 1'b0;
						if (changed_q || (e_ok && rlx_ctl.wr_en)) begin
							state_q <= S_EDGE;
						end else begin
							done_q      <= 1'b1;
							kind_q      <= KIND_SOLVE;
							node_id_q   <= node_q;
							path_cost_q <= '0;
							reachable_q <= 1'b1;
							emit_q      <= 1'b0;
							state_q     <= S_IDLE;
						end
					end else begin
						edge_idx_q <= edge_idx_q + 1'b1;
						state_q    <= S_EDGE;
					end
				end
				S_READ: begin
					done_q    <= 1'b1;
					kind_q    <= KIND_READ;
					node_id_q <= node_q;
					if (ok_q && c_rdata_a < INF) begin
						path_cost_q <= cost32[15:0];
						reachable_q <= 1'b1;
					end else begin
						path_cost_q <= '0;
						reachable_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign kind       = kind_q;
	assign node_id    = node_id_q;
	assign path_cost  = path_cost_q;
	assign reachable  = reachable_q;
	assign error_flag = err_q;

	// Checks on the sequencer.
	`MPR_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
	`MPR_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
	`MPR_ASSERT_NOW(a_store_bound, 1'b1, edge_total_q <= FULL, "edge count above capacity")
	`MPR_ASSERT_NOW(a_relax_finite, state_q == S_RELAX && rlx_ctl.wr_en, rlx_cost < INF,
		"relaxation wrote an infinite cost")

endmodule
